// File: src/npp_pkg.sv
// ----------------------------------------------------------------------------
// npp_pkg: shared types and constants
// Command and status groups between controller and datapath, reset values.
// ----------------------------------------------------------------------------
package npp_pkg;

  localparam int VALUE_BITS_DEF = 20;
  localparam int INDEX_BITS     = 16;
  localparam logic [31:0] LIMIT_RESET = 32'd1000000;

  // controller -> datapath
  typedef struct packed {
    logic load_item;    // capture a new input beat
    logic init_div;     // first odd divisor, d = 3
    logic next_div;     // advance to the next odd divisor
    logic div_start;    // kick the remainder unit
    logic count_inc;    // one more prime seen
    logic step_term;    // move on to the next term
    logic load_result;  // write the output register
    logic result_found; // flag written with the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic want_zero;
    logic term_ge_limit;
    logic term_lt2;
    logic term_lt4;
    logic term_even;
    logic sq_gt_term;
    logic div_done;
    logic rem_zero;
    logic count_hit;
    logic step_zero;
  } status_t;

endpackage

// File: src/nth_prime_in_progression.sv
// Search time is data dependent; each odd term from 5 up runs the remainder unit
//   once per odd trial divisor d with d*d <= term, up to the first zero remainder.
// Throughput: one beat at a time; the iterative remainder unit sets the pace.
// A finished result sits in the output register, so the next beat may be taken
//   while it waits. Reset (rst, synchronous) empties the block and sets the
//   search limit to 1000000, truncated to VALUE_BITS.
// ----------------------------------------------------------------------------
// nth_prime_in_progression: n-th prime of an arithmetic progression
// Walks start, start+step, ... below the search limit and tests each term by
// trial division; returns the term where the n-th prime is found.
// ----------------------------------------------------------------------------
module nth_prime_in_progression #(
  parameter int VALUE_BITS = npp_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // search limit register
  input  logic                           search_limit_we,
  input  logic [VALUE_BITS-1:0]          search_limit_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [VALUE_BITS-1:0]          start_value,
  input  logic [VALUE_BITS-1:0]          step_value,
  input  logic [npp_pkg::INDEX_BITS-1:0] prime_index,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           prime_found,
  output logic [VALUE_BITS-1:0]          prime_value
);

  // command / status between sequencer and datapath
  npp_pkg::cmd_t    cmd;
  npp_pkg::status_t status;

  // sequencer: term loop, divisor loop and both handshakes
  npp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: limit, term, count, divisor, remainder unit, result register
  npp_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .limit_we   (search_limit_we),
    .limit_data (search_limit_data),
    .start_value(start_value),
    .step_value (step_value),
    .prime_index(prime_index),
    .cmd        (cmd),
    .status     (status),
    .prime_found(prime_found),
    .prime_value(prime_value)
  );

  // ---- assertions ----

  // one beat in flight: ready drops straight after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a search was running");

  // not found results carry a zero value
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !prime_found) |-> (prime_value == '0))
    else $error("non-zero value with prime_found low");

  // a found prime is at least 2
  a_found_is_prime_sized: assert property (@(posedge clk) disable iff (rst)
    (out_valid && prime_found) |-> (prime_value >= VALUE_BITS'(2)))
    else $error("found value below 2");

endmodule

// File: src/npp_divider.sv
// ----------------------------------------------------------------------------
// npp_divider: iterative remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module npp_divider #(
  parameter int VALUE_BITS = npp_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] remainder
);

  localparam int CntW = $clog2(VALUE_BITS + 1);

  logic                  busy;
  logic [CntW-1:0]       cnt;
  logic [VALUE_BITS-1:0] dvd;
  logic [VALUE_BITS-1:0] dvsr;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;

  assign trial = {remainder, dvd[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvsr      <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvsr}) begin
        remainder <= diff[VALUE_BITS-1:0];
      end else begin
        remainder <= trial[VALUE_BITS-1:0];
      end
    end
  end

endmodule

// File: src/npp_datapath.sv
// ----------------------------------------------------------------------------
// npp_datapath: term walk, divisor tracking and result register
// Holds the limit register, the current term, prime count and trial divisor.
// ----------------------------------------------------------------------------
module npp_datapath #(
  parameter int VALUE_BITS = npp_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            limit_we,
  input  logic [VALUE_BITS-1:0]           limit_data,
  input  logic [VALUE_BITS-1:0]           start_value,
  input  logic [VALUE_BITS-1:0]           step_value,
  input  logic [npp_pkg::INDEX_BITS-1:0]  prime_index,
  input  npp_pkg::cmd_t                   cmd,
  output npp_pkg::status_t                status,
  output logic                            prime_found,
  output logic [VALUE_BITS-1:0]           prime_value
);

  localparam int IW = npp_pkg::INDEX_BITS;
  localparam logic [VALUE_BITS-1:0] LimitInit = npp_pkg::LIMIT_RESET[VALUE_BITS-1:0];

  logic [VALUE_BITS-1:0] limit;
  logic [VALUE_BITS:0]   term;   // one spare bit: term + step may pass the limit
  logic [VALUE_BITS-1:0] step;
  logic [IW-1:0]         want;
  logic [IW-1:0]         count;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS+1:0] sq;     // d * d, kept incrementally
  logic                  div_done;
  logic [VALUE_BITS-1:0] rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LimitInit;
    end else if (limit_we) begin
      limit <= limit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      term  <= {1'b0, start_value};
      step  <= step_value;
      want  <= prime_index;
      count <= '0;
    end else begin
      if (cmd.step_term) begin
        term <= term + {1'b0, step};
      end
      if (cmd.count_inc) begin
        count <= count + IW'(1);
      end
    end
    if (cmd.init_div) begin
      d  <= VALUE_BITS'(3);
      sq <= (VALUE_BITS+2)'(9);
    end else if (cmd.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      d  <= d + VALUE_BITS'(2);
      sq <= sq + {d, 2'b00} + (VALUE_BITS+2)'(4);
    end
    if (cmd.load_result) begin
      prime_found <= cmd.result_found;
      prime_value <= cmd.result_found ? term[VALUE_BITS-1:0] : '0;
    end
  end

  npp_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (term[VALUE_BITS-1:0]),
    .divisor  (d),
    .done     (div_done),
    .remainder(rem)
  );

  always_comb begin
    status.want_zero     = (want == '0);
    status.term_ge_limit = (term >= {1'b0, limit});
    status.term_lt2      = (term < (VALUE_BITS+1)'(2));
    status.term_lt4      = (term < (VALUE_BITS+1)'(4));
    status.term_even     = ~term[0];
    status.sq_gt_term    = (sq > {1'b0, term});
    status.div_done      = div_done;
    status.rem_zero      = (rem == '0);
    status.count_hit     = (IW'(count + IW'(1)) == want);
    status.step_zero     = (step == '0);
  end

endmodule

// File: src/npp_controller.sv
// ----------------------------------------------------------------------------
// npp_controller: search sequencer
// Steps through terms and trial divisors, drives the handshakes.
// ----------------------------------------------------------------------------
module npp_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  npp_pkg::status_t  status,
  output npp_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_TEST  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_PRIME = 3'd4;
  localparam logic [2:0] ST_NEXT  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       found;
  logic       found_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    found_next = found;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          found_next    = 1'b0;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.want_zero || status.term_ge_limit) begin
          state_next = ST_DONE;
        end else if (status.term_lt2) begin
          state_next = ST_NEXT;
        end else if (status.term_lt4) begin
          state_next = ST_PRIME;
        end else if (status.term_even) begin
          state_next = ST_NEXT;
        end else begin
          cmd.init_div = 1'b1;
          state_next   = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.sq_gt_term) begin
          state_next = ST_PRIME;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            state_next = ST_NEXT;
          end else begin
            cmd.next_div = 1'b1;
            state_next   = ST_TEST;
          end
        end
      end
      ST_PRIME: begin
        cmd.count_inc = 1'b1;
        if (status.count_hit) begin
          found_next = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (status.step_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.step_term = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_DONE: begin
        // output register free, or its beat leaves this cycle
        if (!out_valid || out_ready) begin
          cmd.load_result  = 1'b1;
          cmd.result_found = found;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
